// File: sv/majority_bit_sampler_alarm_timers_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the majority bit sampler core
// Shared by the checker, clocked on clk, reset rst_n (active low).
// ---------------------------------------------------------------------------
`ifndef MAJORITY_BIT_SAMPLER_ALARM_TIMERS_CORE_DEFINES_SVH
`define MAJORITY_BIT_SAMPLER_ALARM_TIMERS_CORE_DEFINES_SVH

// checked only outside reset
`define MBSAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define MBSAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mbsat_pkg.sv
// ---------------------------------------------------------------------------
// mbsat_pkg
// Types, sizes and helpers shared by the majority bit sampler core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbsat_pkg;

  localparam int FRAME_BITS    = 10;
  localparam int WARMUP_BITS   = 11;
  localparam int MAX_SAMPLES   = 255;
  localparam int COUNTER_WIDTH = 16;

  localparam int LIM_W  = 16;
  localparam int TIME_W = 16;
  localparam int FPOS_W = 4;
  localparam int IDX_W  = $clog2(FRAME_BITS);
  localparam int WARM_W = $clog2(WARMUP_BITS + 2);
  localparam int SCNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CNT_W  = COUNTER_WIDTH;

  localparam logic [31:0] CNT_MAX32 = 32'((64'd1 << CNT_W) - 64'd1);

  // reset values of the limit registers
  localparam logic [LIM_W-1:0] WATER_LIMIT_RST  = 16'd200;
  localparam logic [LIM_W-1:0] GAS_LIMIT_RST    = 16'd100;
  localparam logic [LIM_W-1:0] SMOKE_H_LIM_RST  = 16'd100;
  localparam logic [LIM_W-1:0] SMOKE_M_LIM_RST  = 16'd300;

  // frame slots
  localparam int SLOT_WATER = 1;
  localparam int SLOT_SMOKE = 2;
  localparam int SLOT_LEVEL = 3;
  localparam int SLOT_GAS   = 4;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_BIT_END = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_WATER_LIMIT   = 2'd0,
    REG_GAS_LIMIT     = 2'd1,
    REG_SMOKE_H_LIMIT = 2'd2,
    REG_SMOKE_M_LIMIT = 2'd3
  } reg_idx_e;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LIM_W-1:0]  lim_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    lim_t water;
    lim_t gas;
    lim_t smoke_high;
    lim_t smoke_medium;
  } limits_t;

  // frame slots watched by the timers
  typedef struct packed {
    logic water;
    logic gas;
    logic smoke;
    logic level;
  } slots_t;

  typedef struct packed {
    logic              decided_bit;
    logic [FPOS_W-1:0] frame_position;
    logic              warmed_up;
  } bit_res_t;

  typedef struct packed {
    logic  water_alarm;
    logic  gas_alarm;
    logic  smoke_high_alarm;
    logic  smoke_medium_alarm;
    time_t water_time;
    time_t gas_time;
    time_t smoke_high_time;
    time_t smoke_medium_time;
  } alarm_res_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CNT_W'(CNT_MAX32)) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic cnt_ge(cnt_t c, lim_t lim);
    return 32'(c) >= 32'(lim);
  endfunction

  function automatic cnt_t lim_clamp(lim_t lim);
    return (32'(lim) > CNT_MAX32) ? CNT_W'(CNT_MAX32) : CNT_W'(32'(lim));
  endfunction

  function automatic time_t to_time(cnt_t c);
    return TIME_W'(32'(c));
  endfunction

endpackage

// File: sv/mbsat_sampler.sv
// ---------------------------------------------------------------------------
// mbsat_sampler
// Sample counting, majority decision, frame store and warm-up tracking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbsat_sampler (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  mbsat_pkg::op_e    op,
  input  logic              line_bit,
  output mbsat_pkg::slots_t slots_nxt,
  output mbsat_pkg::bit_res_t res_nxt
);
  import mbsat_pkg::*;

  logic [SCNT_W-1:0]     samp_r, samp_nxt;
  logic [SCNT_W-1:0]     ones_r, ones_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [WARM_W-1:0]     warm_r, warm_nxt;
  logic [IDX_W:0]        idx_inc;
  logic                  decided;

  assign decided = {ones_r, 1'b0} > {1'b0, samp_r};
  assign idx_inc = {1'b0, idx_r} + (IDX_W+1)'(1);

  always_comb begin
    samp_nxt  = samp_r;
    ones_nxt  = ones_r;
    frame_nxt = frame_r;
    idx_nxt   = idx_r;
    warm_nxt  = warm_r;
    if (step) begin
      unique case (op)
        OP_SAMPLE: begin
          if (samp_r < SCNT_W'(MAX_SAMPLES)) begin
            samp_nxt = samp_r + SCNT_W'(1);
            ones_nxt = ones_r + SCNT_W'(line_bit);
          end
        end
        OP_BIT_END: begin
          samp_nxt = '0;
          ones_nxt = '0;
          for (int i = 0; i < FRAME_BITS; i++) begin
            if (idx_r == IDX_W'(i)) frame_nxt[i] = decided;
          end
          if (warm_r <= WARM_W'(WARMUP_BITS)) warm_nxt = warm_r + WARM_W'(1);
          if (idx_inc >= (IDX_W+1)'(FRAME_BITS)) idx_nxt = '0;
          else idx_nxt = idx_inc[IDX_W-1:0];
          // one-time frame flush at the end of warm-up
          if (warm_nxt == WARM_W'(WARMUP_BITS)) begin
            idx_nxt   = '0;
            frame_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_r  <= '0;
      ones_r  <= '0;
      frame_r <= '0;
      idx_r   <= '0;
      warm_r  <= '0;
    end else begin
      samp_r  <= samp_nxt;
      ones_r  <= ones_nxt;
      frame_r <= frame_nxt;
      idx_r   <= idx_nxt;
      warm_r  <= warm_nxt;
    end
  end

  assign slots_nxt.water = frame_nxt[SLOT_WATER];
  assign slots_nxt.gas   = frame_nxt[SLOT_GAS];
  assign slots_nxt.smoke = frame_nxt[SLOT_SMOKE];
  assign slots_nxt.level = frame_nxt[SLOT_LEVEL];

  assign res_nxt.decided_bit    = decided;
  assign res_nxt.frame_position = FPOS_W'(32'(idx_nxt));
  assign res_nxt.warmed_up      = warm_nxt > WARM_W'(WARMUP_BITS);

endmodule

// File: sv/mbsat_timers.sv
// ---------------------------------------------------------------------------
// mbsat_timers
// Persistence counters and alarm flags for water, gas and smoke.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbsat_timers (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  mbsat_pkg::slots_t     slots,
  input  mbsat_pkg::limits_t    lim,
  output mbsat_pkg::alarm_res_t res_nxt
);
  import mbsat_pkg::*;

  cnt_t water_r, water_nxt, gas_r, gas_nxt;
  cnt_t high_r, high_nxt, med_r, med_nxt;
  logic [3:0] flags_r, flags_nxt;  // water, gas, high, medium
  cnt_t med_base;

  always_comb begin
    water_nxt = water_r;
    gas_nxt   = gas_r;
    high_nxt  = high_r;
    med_nxt   = med_r;
    flags_nxt = flags_r;
    med_base  = med_r;
    if (fire) begin
      if (slots.water) water_nxt = sat_inc(water_r);
      else begin
        water_nxt    = '0;
        flags_nxt[3] = 1'b0;
      end
      if (cnt_ge(water_nxt, lim.water)) flags_nxt[3] = 1'b1;

      if (slots.gas) gas_nxt = sat_inc(gas_r);
      else begin
        gas_nxt      = '0;
        flags_nxt[2] = 1'b0;
      end
      if (cnt_ge(gas_nxt, lim.gas)) flags_nxt[2] = 1'b1;

      if (slots.smoke) begin
        if (slots.level) begin
          high_nxt = sat_inc(high_r);
          med_nxt  = '0;
        end else begin
          // level drop after high smoke reached its limit counts medium on from its limit
          if (cnt_ge(high_r, lim.smoke_high)) med_base = lim_clamp(lim.smoke_medium);
          med_nxt  = sat_inc(med_base);
          high_nxt = '0;
        end
      end else begin
        high_nxt       = '0;
        med_nxt        = '0;
        flags_nxt[1:0] = 2'b00;
      end
      if (cnt_ge(high_nxt, lim.smoke_high)) flags_nxt[1:0] = 2'b10;
      if (cnt_ge(med_nxt, lim.smoke_medium)) flags_nxt[1:0] = 2'b01;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      water_r <= '0;
      gas_r   <= '0;
      high_r  <= '0;
      med_r   <= '0;
      flags_r <= '0;
    end else begin
      water_r <= water_nxt;
      gas_r   <= gas_nxt;
      high_r  <= high_nxt;
      med_r   <= med_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign res_nxt.water_alarm        = flags_nxt[3];
  assign res_nxt.gas_alarm          = flags_nxt[2];
  assign res_nxt.smoke_high_alarm   = flags_nxt[1];
  assign res_nxt.smoke_medium_alarm = flags_nxt[0];
  assign res_nxt.water_time         = to_time(water_nxt);
  assign res_nxt.gas_time           = to_time(gas_nxt);
  assign res_nxt.smoke_high_time    = to_time(high_nxt);
  assign res_nxt.smoke_medium_time  = to_time(med_nxt);

endmodule

// File: sv/majority_bit_sampler_alarm_timers_core.sv
// ---------------------------------------------------------------------------
// majority_bit_sampler_alarm_timers_core
// Path: a bit-end beat passes the input register, then the result register,
//   before it shows on the result port; samples give no result.
// Throughput: one beat per cycle; input stalls only while a bit-end beat
//   waits in the input register behind a held result.
// Reset: synchronous rst_n clears counters, frame, alarms, limits to defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module majority_bit_sampler_alarm_timers_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic                           in_line_bit,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_decided_bit,
  output logic [mbsat_pkg::FPOS_W-1:0]   out_frame_position,
  output logic                           out_warmed_up,
  output logic                           out_water_alarm,
  output logic                           out_gas_alarm,
  output logic                           out_smoke_high_alarm,
  output logic                           out_smoke_medium_alarm,
  output logic [mbsat_pkg::TIME_W-1:0]   out_water_time,
  output logic [mbsat_pkg::TIME_W-1:0]   out_gas_time,
  output logic [mbsat_pkg::TIME_W-1:0]   out_smoke_high_time,
  output logic [mbsat_pkg::TIME_W-1:0]   out_smoke_medium_time,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import mbsat_pkg::*;

  // Limit registers, word-addressed by paddr[3:2]; low two address bits
  // are not decoded.
  limits_t  lim_r, lim_nxt;
  reg_idx_e reg_sel;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    lim_nxt = lim_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_WATER_LIMIT:   lim_nxt.water        = pwdata[LIM_W-1:0];
        REG_GAS_LIMIT:     lim_nxt.gas          = pwdata[LIM_W-1:0];
        REG_SMOKE_H_LIMIT: lim_nxt.smoke_high   = pwdata[LIM_W-1:0];
        REG_SMOKE_M_LIMIT: lim_nxt.smoke_medium = pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WATER_LIMIT:   prdata = 32'(lim_r.water);
      REG_GAS_LIMIT:     prdata = 32'(lim_r.gas);
      REG_SMOKE_H_LIMIT: prdata = 32'(lim_r.smoke_high);
      REG_SMOKE_M_LIMIT: prdata = 32'(lim_r.smoke_medium);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.water        <= WATER_LIMIT_RST;
      lim_r.gas          <= GAS_LIMIT_RST;
      lim_r.smoke_high   <= SMOKE_H_LIM_RST;
      lim_r.smoke_medium <= SMOKE_M_LIM_RST;
    end else begin
      lim_r <= lim_nxt;
    end
  end

  // Input register. The held beat moves on (and updates the sampler, and on a
  // bit end the timers) when it is a sample, or when the result register is free or being drained.
  logic s1_valid_r, s1_valid_nxt;
  op_e  s1_op_r;
  logic s1_line_r;
  logic advance, fire;

  assign advance  = s1_valid_r && ((s1_op_r == OP_SAMPLE) || !out_valid || out_ready);
  assign fire     = advance && (s1_op_r == OP_BIT_END);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) s1_valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= op_e'(in_operation);
      s1_line_r <= in_line_bit;
    end
  end

  // Datapath: sampler feeds the updated frame slots to the timers in the
  // same cycle; both present next values to the result register.
  slots_t     slots_nxt;
  bit_res_t   bit_nxt;
  alarm_res_t alarm_nxt;

  mbsat_sampler u_sampler (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .op        (s1_op_r),
    .line_bit  (s1_line_r),
    .slots_nxt (slots_nxt),
    .res_nxt   (bit_nxt)
  );

  mbsat_timers u_timers (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .slots   (slots_nxt),
    .lim     (lim_r),
    .res_nxt (alarm_nxt)
  );

  // Result register
  logic       out_valid_r, out_valid_nxt;
  bit_res_t   bit_r;
  alarm_res_t alarm_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      bit_r   <= bit_nxt;
      alarm_r <= alarm_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_decided_bit        = bit_r.decided_bit;
  assign out_frame_position     = bit_r.frame_position;
  assign out_warmed_up          = bit_r.warmed_up;
  assign out_water_alarm        = alarm_r.water_alarm;
  assign out_gas_alarm          = alarm_r.gas_alarm;
  assign out_smoke_high_alarm   = alarm_r.smoke_high_alarm;
  assign out_smoke_medium_alarm = alarm_r.smoke_medium_alarm;
  assign out_water_time         = alarm_r.water_time;
  assign out_gas_time           = alarm_r.gas_time;
  assign out_smoke_high_time    = alarm_r.smoke_high_time;
  assign out_smoke_medium_time  = alarm_r.smoke_medium_time;

endmodule

// File: sv/mbsat_checker.sv
// ---------------------------------------------------------------------------
// mbsat_checker
// Port-level checks on the majority bit sampler core, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "majority_bit_sampler_alarm_timers_core_defines.svh"

module mbsat_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_decided_bit,
  input logic [mbsat_pkg::FPOS_W-1:0] out_frame_position,
  input logic                         out_smoke_high_alarm,
  input logic                         out_smoke_medium_alarm,
  input logic [mbsat_pkg::TIME_W-1:0] out_water_time
);
  import mbsat_pkg::*;

  // held result beat stays put
  `MBSAT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_decided_bit) && $stable(out_frame_position) && $stable(out_water_time), "result changed while stalled")

  // input only stalls behind a stalled result
  `MBSAT_ASSERT(a_stall_cause, in_valid && !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")

  // smoke alarms exclude each other
  `MBSAT_ASSERT(a_smoke_excl, out_valid |-> !(out_smoke_high_alarm && out_smoke_medium_alarm), "both smoke alarms set")

  // nothing valid right after reset
  `MBSAT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind majority_bit_sampler_alarm_timers_core mbsat_checker u_mbsat_checker (.*);

// File: sim/majority_bit_sampler_alarm_timers_core_tb.sv
// ---------------------------------------------------------------------------
// majority_bit_sampler_alarm_timers_core_tb
// Self-checking bench for the majority bit sampler core. Sample and bit-end
// beats go in through valid/ready with random bursts, gaps and result
// stalls. A scoreboard rebuilds the majority decision, the frame, the
// warm-up and the four persistence timers, and checks every result beat
// field by field. Limits are rewritten over APB between phases. A short
// all-ones run followed by a level drop exercises the medium smoke jump.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module majority_bit_sampler_alarm_timers_core_tb;
  import mbsat_pkg::*;

  // timer / alarm order; matches the limit register order
  typedef enum int {
    T_WATER  = 0,
    T_GAS    = 1,
    T_HIGH   = 2,
    T_MEDIUM = 3
  } timer_e;

  typedef struct {
    logic              decided;
    logic [FPOS_W-1:0] pos;
    logic              warm;
    logic              alarm [4];
    time_t             timer [4];
  } bit_report_t;

  // -------------------------------------------------------------------------
  // Scoreboard: predicts one report per bit-end beat, checks in order
  // -------------------------------------------------------------------------
  class alarm_scoreboard;
    lim_t                  lim [4];
    int                    n_samples;
    int                    n_ones;
    logic [FRAME_BITS-1:0] frame;
    int                    slot;
    int                    warm;
    cnt_t                  cnt [4];
    logic                  al [4];
    bit_report_t           expected_q [$];
    int                    errors;
    int                    checked;
    int                    alarm_hits [4];
    int                    sat_hits;
    string                 tname [4];

    function new();
      tname = '{"water", "gas", "smoke_high", "smoke_medium"};
      lim[T_WATER]  = WATER_LIMIT_RST;
      lim[T_GAS]    = GAS_LIMIT_RST;
      lim[T_HIGH]   = SMOKE_H_LIM_RST;
      lim[T_MEDIUM] = SMOKE_M_LIM_RST;
      n_samples = 0;
      n_ones = 0;
      frame = '0;
      slot = 0;
      warm = 0;
      errors = 0;
      checked = 0;
      sat_hits = 0;
      for (int t = 0; t < 4; t++) begin
        cnt[t] = '0;
        al[t] = 1'b0;
        alarm_hits[t] = 0;
      end
    endfunction

    function void set_limit(reg_idx_e idx, lim_t v);
      lim[int'(idx)] = v;
    endfunction

    function int next_slot();
      return slot;
    endfunction

    function bit sampling_full();
      return n_samples >= MAX_SAMPLES;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function cnt_t bump(cnt_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void note_beat(op_e op, logic line);
      bit_report_t r;
      logic        d;
      int          watch [2];
      watch = '{SLOT_WATER, SLOT_GAS};
      if (op == OP_SAMPLE) begin
        // extra samples past the cap are dropped
        if (n_samples < MAX_SAMPLES) begin
          n_samples++;
          n_ones += int'(line);
        end
        return;
      end
      d = (2 * n_ones > n_samples);
      frame[slot] = d;
      slot++;
      if (warm <= WARMUP_BITS) warm++;
      if (slot >= FRAME_BITS) slot = 0;
      if (warm == WARMUP_BITS) begin
        slot = 0;
        frame = '0;
      end
      // water and gas: plain persistence
      for (int t = 0; t < 2; t++) begin
        if (frame[watch[t]]) begin
          cnt[t] = bump(cnt[t]);
        end else begin
          al[t] = 1'b0;
          cnt[t] = '0;
        end
        if (cnt[t] >= lim[t]) al[t] = 1'b1;
      end
      // smoke: level bit picks high or medium
      if (frame[SLOT_SMOKE]) begin
        if (frame[SLOT_LEVEL]) begin
          cnt[T_HIGH] = bump(cnt[T_HIGH]);
          cnt[T_MEDIUM] = '0;
        end else begin
          if (cnt[T_HIGH] >= lim[T_HIGH]) cnt[T_MEDIUM] = lim[T_MEDIUM];
          cnt[T_MEDIUM] = bump(cnt[T_MEDIUM]);
          cnt[T_HIGH] = '0;
        end
      end else begin
        al[T_HIGH] = 1'b0;
        al[T_MEDIUM] = 1'b0;
        cnt[T_HIGH] = '0;
        cnt[T_MEDIUM] = '0;
      end
      if (cnt[T_HIGH] >= lim[T_HIGH]) begin
        al[T_HIGH] = 1'b1;
        al[T_MEDIUM] = 1'b0;
      end
      if (cnt[T_MEDIUM] >= lim[T_MEDIUM]) begin
        al[T_MEDIUM] = 1'b1;
        al[T_HIGH] = 1'b0;
      end
      n_samples = 0;
      n_ones = 0;
      r.decided = d;
      r.pos = FPOS_W'(slot);
      r.warm = (warm > WARMUP_BITS);
      for (int t = 0; t < 4; t++) begin
        r.alarm[t] = al[t];
        r.timer[t] = cnt[t];
      end
      expected_q.push_back(r);
    endfunction

    function void cmp(string what, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        if (errors <= 40)
          $display("%0t mismatch %s: expected %0d, actual %0d", $time, what, e, a);
      end
    endfunction

    function void check_beat(bit_report_t got);
      bit_report_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t result beat with nothing expected (decided %0d pos %0d)",
                   $time, got.decided, got.pos);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      cmp("decided_bit", 32'(e.decided), 32'(got.decided));
      cmp("frame_position", 32'(e.pos), 32'(got.pos));
      cmp("warmed_up", 32'(e.warm), 32'(got.warm));
      for (int t = 0; t < 4; t++) begin
        cmp({tname[t], "_alarm"}, 32'(e.alarm[t]), 32'(got.alarm[t]));
        cmp({tname[t], "_time"}, 32'(e.timer[t]), 32'(got.timer[t]));
        if (e.alarm[t]) alarm_hits[t]++;
        if (e.timer[t] == '1) sat_hits++;
      end
    endfunction

    function void final_check();
      if (expected_q.size() != 0) begin
        errors++;
        $display("%0t %0d expected result beats never arrived", $time, expected_q.size());
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // -------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_operation = 1'b0;
  logic                in_line_bit = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_decided_bit;
  logic [FPOS_W-1:0]   out_frame_position;
  logic                out_warmed_up;
  logic                out_water_alarm;
  logic                out_gas_alarm;
  logic                out_smoke_high_alarm;
  logic                out_smoke_medium_alarm;
  logic [TIME_W-1:0]   out_water_time;
  logic [TIME_W-1:0]   out_gas_time;
  logic [TIME_W-1:0]   out_smoke_high_time;
  logic [TIME_W-1:0]   out_smoke_medium_time;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  majority_bit_sampler_alarm_timers_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_operation           (in_operation),
    .in_line_bit            (in_line_bit),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_decided_bit        (out_decided_bit),
    .out_frame_position     (out_frame_position),
    .out_warmed_up          (out_warmed_up),
    .out_water_alarm        (out_water_alarm),
    .out_gas_alarm          (out_gas_alarm),
    .out_smoke_high_alarm   (out_smoke_high_alarm),
    .out_smoke_medium_alarm (out_smoke_medium_alarm),
    .out_water_time         (out_water_time),
    .out_gas_time           (out_gas_time),
    .out_smoke_high_time    (out_smoke_high_time),
    .out_smoke_medium_time  (out_smoke_medium_time),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  alarm_scoreboard sb = new();

  int                    beats_sent = 0;
  int                    burst_left = 0;
  int                    cfg_writes = 0;
  logic [FRAME_BITS-1:0] plan = '0;   // intended frame content for random bits

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // result side: capture at the rising edge, before the DUT updates
  always @(posedge clk) begin
    bit_report_t got;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      got.decided = out_decided_bit;
      got.pos = out_frame_position;
      got.warm = out_warmed_up;
      got.alarm = '{out_water_alarm, out_gas_alarm, out_smoke_high_alarm,
                    out_smoke_medium_alarm};
      got.timer = '{out_water_time, out_gas_time, out_smoke_high_time,
                    out_smoke_medium_time};
      sb.check_beat(got);
    end
  end

  // receiver pacing: stretches of always-ready, coin flips, 1-in-3, mostly-ready
  initial begin : out_pace
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(8, 64);
      for (int k = 0; k < len; k++) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= (k % 3 == 0);
          end
          default: begin
            out_ready <= ($urandom_range(0, 5) != 0);
          end
        endcase
      end
    end
  end

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------
  // One beat, with a random gap whenever a burst runs out. Valid is only
  // touched at falling edges, once per edge.
  task automatic push_beat(op_e op, logic line);
    int  gap;
    bit  counts;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_line_bit <= line;
    do @(posedge clk); while (in_ready !== 1'b1);
    // samples past the cap do nothing, so they don't count as stimulus
    counts = !(op == OP_SAMPLE && sb.sampling_full());
    sb.note_beat(op, line);
    if (counts) beats_sent++;
  endtask

  // n samples whose majority is 'want' (unless noisy), then the bit end
  task automatic send_bit(logic want, int n, bit noisy);
    int   ones;
    logic b;
    if (n == 0) ones = 0;
    else if (want) ones = $urandom_range(n / 2 + 1, n);
    else ones = $urandom_range(0, n / 2);
    for (int left = n; left > 0; left--) begin
      if (noisy) b = 1'($urandom_range(0, 1));
      else b = ($urandom_range(1, left) <= ones);
      if (b) ones--;
      push_beat(OP_SAMPLE, b);
    end
    // line bit is don't-care on a bit end; toggle it anyway
    push_beat(OP_BIT_END, 1'($urandom_range(0, 1)));
  endtask

  // lower valid and let the pipe empty before touching registers
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write then read-back; upper pwdata bits are junk the core must drop
  task automatic write_limit(reg_idx_e idx, lim_t v);
    logic [31:0] data;
    data = {16'($urandom), v};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_limit(idx, v);
    cfg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.cmp("limit readback", {16'd0, v}, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limits(lim_t w, lim_t g, lim_t h, lim_t m);
    write_limit(REG_WATER_LIMIT, w);
    write_limit(REG_GAS_LIMIT, g);
    write_limit(REG_SMOKE_H_LIMIT, h);
    write_limit(REG_SMOKE_M_LIMIT, m);
  endtask

  // Random bits that mostly follow a frame plan, so the watched slots hold
  // long enough for the timers to run; some noisy or flipped bits, a few
  // empty bits and the odd oversized bit that overruns the sample cap.
  task automatic random_phase(int budget);
    int   start;
    int   pick;
    int   n;
    logic want;
    bit   noisy;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      if ($urandom_range(0, 49) == 0) begin
        plan = FRAME_BITS'($urandom);
        if ($urandom_range(0, 1)) begin
          plan[SLOT_WATER] = 1'b1;
          plan[SLOT_GAS] = 1'b1;
          plan[SLOT_SMOKE] = 1'b1;
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) n = 0;
      else if (pick < 93) n = $urandom_range(1, 5);
      else if (pick < 99) n = $urandom_range(6, 30);
      else n = $urandom_range(250, 270);
      noisy = ($urandom_range(0, 7) == 0);
      want = plan[sb.next_slot()];
      if ($urandom_range(0, 29) == 0) want = ~want;
      send_bit(want, n, noisy);
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : run
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset limits, empty bit, single samples, ties, clear majority
    send_bit(1'b0, 0, 1'b0);
    push_beat(OP_SAMPLE, 1'b1);
    push_beat(OP_BIT_END, 1'b0);
    push_beat(OP_SAMPLE, 1'b0);
    push_beat(OP_BIT_END, 1'b1);
    push_beat(OP_SAMPLE, 1'b1);
    push_beat(OP_SAMPLE, 1'b0);
    push_beat(OP_BIT_END, 1'b0);       // tie decides 0
    push_beat(OP_SAMPLE, 1'b0);
    push_beat(OP_SAMPLE, 1'b1);
    push_beat(OP_SAMPLE, 1'b1);
    push_beat(OP_BIT_END, 1'b1);
    push_beat(OP_SAMPLE, 1'b1);
    push_beat(OP_SAMPLE, 1'b1);
    push_beat(OP_SAMPLE, 1'b0);
    push_beat(OP_SAMPLE, 1'b0);
    push_beat(OP_BIT_END, 1'b0);
    push_beat(OP_BIT_END, 1'b1);       // back-to-back empty bit
    random_phase(220);
    drain();

    // zero limits: every timer trips at once, medium wins over high
    set_limits(16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(270);
    drain();

    // small limits: alarms come and go with the plan
    set_limits(lim_t'($urandom_range(1, 8)), lim_t'($urandom_range(1, 8)),
               lim_t'($urandom_range(1, 8)), lim_t'($urandom_range(1, 8)));
    random_phase(350);
    drain();

    // mixed limits, one at the top; raised limits keep alarms already set
    set_limits(lim_t'($urandom_range(0, 40)), 16'hFFFF,
               lim_t'($urandom_range(0, 40)), lim_t'($urandom_range(0, 40)));
    random_phase(350);
    drain();

    // all-ones bits until high smoke passes its limit, then drop the level
    // slot so medium jumps to its limit and trips
    set_limits(16'd20, 16'd20, 16'd8, 16'd12);
    for (int k = 0; k < 30; k++) send_bit(1'b1, 1, 1'b0);
    for (int k = 0; k < 30; k++) send_bit(sb.next_slot() != SLOT_LEVEL, 1, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.final_check();
    $display("covered %0d input beats, %0d bit results checked, %0d limit writes",
             beats_sent, sb.checked, cfg_writes);
    $display("alarm results: water %0d gas %0d smoke high %0d smoke medium %0d, %0d saturated",
             sb.alarm_hits[T_WATER], sb.alarm_hits[T_GAS], sb.alarm_hits[T_HIGH],
             sb.alarm_hits[T_MEDIUM], sb.sat_hits);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
